// ===== rtl/xor_checked_frame_deframer_core_defines.svh =====
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef XOR_CHECKED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked property, disabled while reset is asserted.
`define XCFD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked during reset as well.
`define XCFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XCFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define XCFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/xcfd_pkg.sv =====
// Types and constants of the XOR-checked frame deframer.
// No dependencies; imported by xcfd_parse and the top level.
package xcfd_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_LEN = 1'b1;

	localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'hAA;
	localparam logic [BYTE_W-1:0] MAX_BODY_LEN_RST = 8'hFF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SUM  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_LEN,
		PH_BODY,
		PH_CHK
	} phase_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] source_id;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] frame_len;
		logic [1:0]        status;
		logic              last;
	} res_t;

endpackage

// ===== rtl/xor_checked_frame_deframer_core.sv =====
// Top level of the XOR-checked frame deframer: config registers, parser, output skid.
// Depends on xcfd_pkg, xcfd_parse and xor_checked_frame_deframer_core_defines.svh.
//
// Usage:
//   rx channel (rx_valid/rx_stall/rx_byte): one received byte per request.
//   res channel (res_valid/res_stall/...): payload results (kind 0) for body
//   bytes after source and command, and one frame-end result (kind 1, last 1)
//   with status ok, bad checksum or too long on the check byte.
//   Config port: cfg_wr_en writes cfg_wdata to register cfg_index
//   (0 start byte, 1 max body length); write only while the block is idle.
// Timing:
//   A byte is taken in every cycle in which rx_stall is low; its result, if any,
//   is registered in the output register, or in the skid register under stall,
//   before it shows on res. Throughput is one byte per cycle while rx_stall is low.
// Reset:
//   arst_n returns the parser to hunting for the start byte, clears held
//   header bytes and loads start byte 0xAA and max body length 255.
// Stall:
//   A stalled result holds in the output register; one more result fits in
//   the skid register, after which rx_stall rises until the output drains.
`include "xor_checked_frame_deframer_core_defines.svh"

module xor_checked_frame_deframer_core #(
	parameter int SKID_EN = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [xcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                      cfg_wdata,
	input  logic                            rx_valid,
	output logic                            rx_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            kind,
	output logic [7:0]                      source_id,
	output logic [7:0]                      command,
	output logic [7:0]                      payload_byte,
	output logic [7:0]                      payload_index,
	output logic [7:0]                      frame_len,
	output logic [1:0]                      status,
	output logic                            last
);
	import xcfd_pkg::*;

	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] max_len_q;
	logic              in_fire;
	logic              out_fire;
	logic              new_valid;
	res_t              new_res;
	logic              out_valid_q;
	res_t              out_q;
	logic              skid_valid_q;
	res_t              skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			max_len_q    <= MAX_BODY_LEN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_START_BYTE:   start_byte_q <= cfg_wdata;
				REG_MAX_BODY_LEN: max_len_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign rx_stall = (SKID_EN != 0) ? skid_valid_q : (out_valid_q && res_stall);
	assign in_fire  = rx_valid && !rx_stall;
	assign out_fire = out_valid_q && !res_stall;

	xcfd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.rx_byte     (rx_byte),
		.start_byte  (start_byte_q),
		.max_body_len(max_len_q),
		.res_valid   (new_valid),
		.res         (new_res)
	);

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_fire) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= new_valid;
			end
		end else if (new_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_fire) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (new_valid) out_q <= new_res;
		end else if (new_valid) begin
			skid_q <= new_res;
		end
	end

	assign res_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign source_id     = out_q.source_id;
	assign command       = out_q.command;
	assign payload_byte  = out_q.payload_byte;
	assign payload_index = out_q.payload_index;
	assign frame_len     = out_q.frame_len;
	assign status        = out_q.status;
	assign last          = out_q.last;

	`XCFD_ASSERT_ALWAYS(a_skid_behind_out, clk,
		skid_valid_q |-> out_valid_q, "skid entry held with empty output register")
	`XCFD_ASSERT(a_skid_fill_on_stall, clk, arst_n,
		$rose(skid_valid_q) |-> $past(out_valid_q && res_stall),
		"skid filled while output was free")
	`XCFD_ASSERT(a_result_not_lost, clk, arst_n,
		(new_valid && out_valid_q && res_stall) |=> skid_valid_q,
		"result dropped under stall")

endmodule

// ===== rtl/xcfd_parse.sv =====
// Frame parser: phase machine, running XOR and held header bytes.
// Depends on xcfd_pkg and xor_checked_frame_deframer_core_defines.svh.
`include "xor_checked_frame_deframer_core_defines.svh"

module xcfd_parse (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [7:0]                 rx_byte,
	input  logic [7:0]                 start_byte,
	input  logic [7:0]                 max_body_len,
	output logic                       res_valid,
	output xcfd_pkg::res_t             res
);
	import xcfd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [BYTE_W-1:0]   xor_q;
	logic [BYTE_W-1:0]   count_q;
	logic [BYTE_W-1:0]   len_q;
	logic [BYTE_W-1:0]   src_q;
	logic [BYTE_W-1:0]   cmd_q;
	logic [BYTE_W-1:0]   count_inc;

	assign count_inc = count_q + 8'd1;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_WAIT: begin
				if (rx_byte == start_byte) phase_d = PH_LEN;
			end
			PH_LEN:  phase_d = PH_BODY;
			PH_BODY: begin
				if (count_inc >= len_q) phase_d = PH_CHK;
			end
			PH_CHK:  phase_d = PH_WAIT;
			default: phase_d = PH_WAIT;
		endcase
	end

	// Result for the byte at the input
	always_comb begin
		res_valid         = 1'b0;
		res.kind          = KIND_PAYLOAD;
		res.source_id     = src_q;
		res.command       = cmd_q;
		res.payload_byte  = '0;
		res.payload_index = '0;
		res.frame_len     = len_q;
		res.status        = ST_OK;
		res.last          = 1'b0;
		unique case (phase_q)
			PH_BODY: begin
				if (count_q >= 8'd2) begin
					res_valid         = fire;
					res.payload_byte  = rx_byte;
					res.payload_index = count_q - 8'd2;
				end
			end
			PH_CHK: begin
				res_valid = fire;
				res.kind  = KIND_END;
				res.last  = 1'b1;
				if (len_q > max_body_len)
					res.status = ST_TOO_LONG;
				else if (xor_q != rx_byte)
					res.status = ST_BAD_SUM;
				else
					res.status = ST_OK;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			xor_q   <= '0;
			count_q <= '0;
			len_q   <= '0;
			src_q   <= '0;
			cmd_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			unique case (phase_q)
				PH_WAIT: begin
					if (rx_byte == start_byte) xor_q <= '0;
				end
				PH_LEN: begin
					len_q   <= rx_byte;
					xor_q   <= xor_q ^ rx_byte;
					count_q <= '0;
				end
				PH_BODY: begin
					if (count_q == 8'd0) src_q <= rx_byte;
					else if (count_q == 8'd1) cmd_q <= rx_byte;
					xor_q   <= xor_q ^ rx_byte;
					count_q <= count_inc;
				end
				default: begin
				end
			endcase
		end
	end

	`XCFD_ASSERT(a_chk_returns_to_wait, clk, arst_n,
		(fire && phase_q == PH_CHK) |=> (phase_q == PH_WAIT), "frame end did not rearm hunt")
	`XCFD_ASSERT(a_len_starts_body, clk, arst_n,
		(fire && phase_q == PH_LEN) |=> (phase_q == PH_BODY && count_q == 8'd0),
		"LEN byte did not open the body")
	`XCFD_ASSERT(a_body_count_bound, clk, arst_n,
		(phase_q == PH_BODY) |-> (count_q < len_q || count_q == 8'd0),
		"body count ran past LEN")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for xor_checked_frame_deframer_core: predicts each result from the bytes
// it sends and compares every result the block returns. Depends on xcfd_pkg and the RTL.
module tb_top;
	import xcfd_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_wdata;
	logic                 rx_valid;
	logic                 rx_stall;
	logic [7:0]           rx_byte;
	logic                 res_valid;
	logic                 res_stall;
	logic                 kind;
	logic [7:0]           source_id;
	logic [7:0]           command;
	logic [7:0]           payload_byte;
	logic [7:0]           payload_index;
	logic [7:0]           frame_len;
	logic [1:0]           status;
	logic                 last;

	// deframer state as predicted from the accepted bytes
	phase_t     ph;
	logic [7:0] sum_x;
	logic [7:0] body_n;
	logic [7:0] len_f;
	logic [7:0] src_h;
	logic [7:0] cmd_h;
	logic [7:0] cfg_start;
	logic [7:0] cfg_max;

	res_t pending_res[$];
	int   mismatches;
	int   bytes_sent;
	bit   rx_steady;
	bit   res_steady;
	int   hold_seq;
	int   hold_seen;

	xor_checked_frame_deframer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.source_id    (source_id),
		.command      (command),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.frame_len    (frame_len),
		.status       (status),
		.last         (last)
	);

	always #5 clk = ~clk;

	function automatic void deframe_byte(input logic [7:0] b);
		res_t r;
		r = '0;
		r.kind = KIND_PAYLOAD;
		r.status = ST_OK;
		case (ph)
			PH_WAIT: begin
				if (b == cfg_start) begin
					sum_x = 8'h00;
					ph = PH_LEN;
				end
			end
			PH_LEN: begin
				len_f = b;
				sum_x = sum_x ^ b;
				body_n = 8'h00;
				ph = PH_BODY;
			end
			PH_BODY: begin
				if (body_n == 8'd0) begin
					src_h = b;
				end else if (body_n == 8'd1) begin
					cmd_h = b;
				end else begin
					r.source_id = src_h;
					r.command = cmd_h;
					r.payload_byte = b;
					r.payload_index = body_n - 8'd2;
					r.frame_len = len_f;
					r.last = 1'b0;
					pending_res.push_back(r);
				end
				sum_x = sum_x ^ b;
				body_n = body_n + 8'd1;
				if (body_n >= len_f)
					ph = PH_CHK;
			end
			default: begin
				r.kind = KIND_END;
				r.source_id = src_h;
				r.command = cmd_h;
				r.frame_len = len_f;
				// too long wins over a bad check byte
				if (len_f > cfg_max)
					r.status = ST_TOO_LONG;
				else if (sum_x != b)
					r.status = ST_BAD_SUM;
				else
					r.status = ST_OK;
				r.last = 1'b1;
				pending_res.push_back(r);
				ph = PH_WAIT;
			end
		endcase
	endfunction

	function automatic string res_text(input res_t r);
		return $sformatf("kind=%0d src=%h cmd=%h byte=%h idx=%0d len=%0d st=%0d last=%0d",
			r.kind, r.source_id, r.command, r.payload_byte, r.payload_index,
			r.frame_len, r.status, r.last);
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// result checker
	always @(posedge clk) begin
		res_t  got;
		res_t  want;
		string diff;
		if (arst_n && res_valid && !res_stall) begin
			got = '{kind, source_id, command, payload_byte, payload_index,
				frame_len, status, last};
			if (pending_res.size() == 0) begin
				note_mismatch({"unexpected result: ", res_text(got)});
			end else begin
				want = pending_res.pop_front();
				diff = "";
				if (got.kind !== want.kind) diff = {diff, " kind"};
				if (got.source_id !== want.source_id) diff = {diff, " source_id"};
				if (got.command !== want.command) diff = {diff, " command"};
				if (got.payload_byte !== want.payload_byte) diff = {diff, " payload_byte"};
				if (got.payload_index !== want.payload_index) diff = {diff, " payload_index"};
				if (got.frame_len !== want.frame_len) diff = {diff, " frame_len"};
				if (got.status !== want.status) diff = {diff, " status"};
				if (got.last !== want.last) diff = {diff, " last"};
				if (diff != "")
					note_mismatch({"field mismatch:", diff, "\n  expected ", res_text(want),
						"\n  actual   ", res_text(got)});
			end
		end
	end

	// receiver: random stalls, quiet stretches, and a long hold-off on request
	initial begin
		res_stall = 1'b0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				res_stall <= 1'b1;
				for (int i = 1; i < HOLD_CYCLES; i++)
					@(posedge clk);
			end else begin
				res_stall <= !res_steady && ($urandom_range(99) < 13);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (!rx_steady && $urandom_range(99) < 13) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		deframe_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] len, input bit good_sum);
		logic [7:0] x;
		logic [7:0] b;
		int         n;
		n = (len < 2) ? 1 : len;
		send_byte(cfg_start);
		send_byte(len);
		x = len;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(255));
			send_byte(b);
			x = x ^ b;
		end
		if (!good_sum)
			x = x ^ 8'($urandom_range(1, 255));
		send_byte(x);
		bytes_sent += n + 3;
	endtask

	// drop the request and wait until every predicted result is back
	task automatic settle();
		rx_valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_START_BYTE)
			cfg_start = val;
		else
			cfg_max = val;
	endtask

	task automatic test_directed();
		// noise while hunting
		send_byte(8'h00);
		send_byte(8'hFF);
		// start byte inside the body, extreme body values, good check byte
		send_byte(8'hAA); send_byte(8'h04); send_byte(8'hFF); send_byte(8'h00);
		send_byte(8'hAA); send_byte(8'h55); send_byte(8'h04);
		// LEN 0 and LEN 1 take only the source byte
		send_byte(8'hAA); send_byte(8'h00); send_byte(8'h12); send_byte(8'h12);
		send_byte(8'hAA); send_byte(8'h01); send_byte(8'h34); send_byte(8'h35);
		// header only, bad check byte
		send_byte(8'hAA); send_byte(8'h02); send_byte(8'h56); send_byte(8'h78);
		send_byte(8'h2D);
	endtask

	task automatic test_registers();
		set_reg(REG_MAX_BODY_LEN, 8'd3);
		send_frame(8'd5, 1'b1);
		send_frame(8'd5, 1'b0);
		send_frame(8'd3, 1'b1);
		set_reg(REG_MAX_BODY_LEN, 8'd0);
		send_frame(8'd0, 1'b1);
		send_frame(8'd1, 1'b1);
		set_reg(REG_START_BYTE, 8'h00);
		send_byte(8'hAA);
		send_frame(8'd4, 1'b1);
		set_reg(REG_START_BYTE, 8'hFF);
		set_reg(REG_MAX_BODY_LEN, 8'hFF);
		send_frame(8'd6, 1'b0);
		send_frame(8'd6, 1'b1);
	endtask

	task automatic random_traffic(input int n_bytes);
		int target;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			if ($urandom_range(99) < 15)
				send_byte(8'($urandom_range(255)));
			else if ($urandom_range(99) < 4)
				send_frame(8'($urandom_range(100, 255)), $urandom_range(99) < 75);
			else
				send_frame(8'($urandom_range(0, 16)), $urandom_range(99) < 75);
		end
	endtask

	task automatic test_random();
		set_reg(REG_START_BYTE, 8'($urandom_range(255)));
		set_reg(REG_MAX_BODY_LEN, 8'($urandom_range(255)));
		random_traffic(150);
		set_reg(REG_START_BYTE, 8'h00);
		set_reg(REG_MAX_BODY_LEN, 8'h00);
		// no idling on either side for this stretch
		rx_steady = 1'b1;
		res_steady = 1'b1;
		random_traffic(150);
		rx_steady = 1'b0;
		res_steady = 1'b0;
		set_reg(REG_START_BYTE, 8'hFF);
		set_reg(REG_MAX_BODY_LEN, 8'hFF);
		send_frame(8'd255, 1'b1);
		random_traffic(80);
		// sender pause: hold off until the block has drained
		settle();
		random_traffic(80);
		set_reg(REG_START_BYTE, 8'hAA);
		set_reg(REG_MAX_BODY_LEN, 8'($urandom_range(2, 20)));
		random_traffic(150);
	endtask

	task automatic test_backpressure();
		// receiver holds off while the sender keeps the request up
		hold_seq++;
		rx_steady = 1'b1;
		send_frame(8'd60, 1'b1);
		send_frame(8'd8, 1'b0);
		rx_steady = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_START_BYTE;
		cfg_wdata = 8'h00;
		rx_valid = 1'b0;
		rx_byte = 8'h00;
		mismatches = 0;
		bytes_sent = 0;
		rx_steady = 1'b0;
		res_steady = 1'b0;
		hold_seq = 0;
		ph = PH_WAIT;
		sum_x = 8'h00;
		body_n = 8'h00;
		len_f = 8'h00;
		src_h = 8'h00;
		cmd_h = 8'h00;
		cfg_start = START_BYTE_RST;
		cfg_max = MAX_BODY_LEN_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_registers();
		test_backpressure();
		test_random();

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/xcfd_pkg.sv
rtl/xcfd_parse.sv
rtl/xor_checked_frame_deframer_core.sv
verif/tb_top.sv
